FILE: hdl/tcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants for the text console engine
// Holds the request and result payload types, the controller state type
// and the character and cell codes used across the design.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // Fixed payload widths.
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = 16;
    localparam int IDX_W     = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Cell and character codes.
    localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL     = 16'h0720;
    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
    localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;

    // Request actions.
    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } in_t;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_data;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic                 scrolled;
    } out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESP,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/tcc_screen_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_screen_mem: screen cell store
// Simple dual-port synchronous memory, one write and one read port, with
// registered read data.
// ----------------------------------------------------------------------------
module tcc_screen_mem #(
    parameter int DEPTH  = tcc_pkg::DEF_COLUMNS * tcc_pkg::DEF_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [ADDR_W-1:0]         waddr,
    input  wire logic [tcc_pkg::CELL_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [ADDR_W-1:0]         raddr,
    output logic      [tcc_pkg::CELL_W-1:0] rdata
);

    logic [tcc_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcc_pkg::CELL_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: hdl/tcc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_ctrl: console sequencer
// Owns the cursor and attribute registers, decodes each request into
// memory reads and writes, runs the clearing pass after reset and the
// scroll copy, and hands one result per request to the output stage.
// ----------------------------------------------------------------------------
module tcc_ctrl #(
    parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcc_pkg::DEF_ROWS,
    parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Request channel.
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire tcc_pkg::in_t                  in_data,
    // Attribute register write.
    input  wire logic                          cfg_wr_en,
    input  wire logic [tcc_pkg::ATTR_W-1:0]    cfg_wr_data,
    // Result handoff to the output stage.
    output logic                               resp_valid,
    input  wire logic                          resp_ready,
    output tcc_pkg::out_t                      resp_data,
    // Memory ports.
    output logic                               mem_we,
    output logic      [ADDR_W-1:0]             mem_waddr,
    output logic      [tcc_pkg::CELL_W-1:0]    mem_wdata,
    output logic                               mem_re,
    output logic      [ADDR_W-1:0]             mem_raddr,
    input  wire logic [tcc_pkg::CELL_W-1:0]    mem_rdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);
    localparam logic [RW-1:0]     LAST_ROW   = RW'(ROWS - 1);
    localparam logic [CW-1:0]     LAST_COL   = CW'(COLUMNS - 1);

    tcc_pkg::state_t             state_reg, state_next;
    logic [ADDR_W-1:0]           cnt_reg, cnt_next;
    logic [RW-1:0]               row_reg, row_next;
    logic [CW-1:0]               col_reg, col_next;
    logic [tcc_pkg::ATTR_W-1:0]  attr_reg, attr_next;
    logic                        scrolled_reg, scrolled_next;
    logic                        read_ok_reg, read_ok_next;
    logic                        pend_reg, pend_next;
    logic [ADDR_W-1:0]           pend_addr_reg, pend_addr_next;

    logic [ADDR_W-1:0]           row_base;
    logic [tcc_pkg::CELL_W-1:0]  blank_cell;

    // Linear address of the start of the cursor row.
    assign row_base   = ADDR_W'(row_reg) * ROW_STEP;
    assign blank_cell = {attr_reg, tcc_pkg::BLANK_CHAR};

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tcc_pkg::ST_CLEAR;
            cnt_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            attr_reg     <= tcc_pkg::ATTR_RESET;
            scrolled_reg <= 1'b0;
            read_ok_reg  <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            attr_reg     <= attr_next;
            scrolled_reg <= scrolled_next;
            read_ok_reg  <= read_ok_next;
            pend_reg     <= pend_next;
        end
    end

    // Destination of the copy write, issued in the cycle after its read.
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
    end

    // Next state, cursor update and memory commands.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        attr_next      = cfg_wr_en ? cfg_wr_data : attr_reg;
        scrolled_next  = scrolled_reg;
        read_ok_next   = read_ok_reg;
        pend_next      = 1'b0;
        pend_addr_next = cnt_reg;
        in_ready       = 1'b0;
        resp_valid     = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        unique case (state_reg)
            // Fill every cell with the reset cell after reset.
            tcc_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = tcc_pkg::RESET_CELL;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = tcc_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Take a request and issue its memory access in the same cycle.
            tcc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    scrolled_next = 1'b0;
                    read_ok_next  = 1'b0;
                    state_next    = tcc_pkg::ST_RESP;
                    if (in_data.action == tcc_pkg::ACT_READ)
                    begin
                        mem_re       = 1'b1;
                        mem_raddr    = ADDR_W'(in_data.cell_index);
                        read_ok_next = (32'(in_data.cell_index) < 32'(CELLS));
                    end
                    else if (in_data.char_code == tcc_pkg::NEWLINE_CHAR)
                    begin
                        col_next = '0;
                        if (row_reg == LAST_ROW)
                        begin
                            scrolled_next = 1'b1;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else if (in_data.char_code == tcc_pkg::BACKSPACE_CHAR)
                    begin
                        if (col_reg != '0)
                        begin
                            col_next  = col_reg - 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = row_base + ADDR_W'(col_reg - 1'b1);
                            mem_wdata = blank_cell;
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = row_base + ADDR_W'(col_reg);
                        mem_wdata = {attr_reg, in_data.char_code};
                        if (col_reg == LAST_COL)
                        begin
                            col_next = '0;
                            if (row_reg == LAST_ROW)
                            begin
                                scrolled_next = 1'b1;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    // A scroll starts the copy pass before the result goes out.
                    if (in_data.action == tcc_pkg::ACT_PUT && scrolled_next)
                    begin
                        cnt_next   = '0;
                        state_next = tcc_pkg::ST_COPY;
                    end
                end
            end

            // Move each cell up one row: read one row below, write in the next cycle.
            tcc_pkg::ST_COPY:
            begin
                mem_re         = 1'b1;
                mem_raddr      = cnt_reg + ROW_STEP;
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg;
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = mem_rdata;
                end
                if (cnt_reg == LAST_COPY)
                begin
                    state_next = tcc_pkg::ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Finish the last copy write.
            tcc_pkg::ST_DRAIN:
            begin
                mem_we     = pend_reg;
                mem_waddr  = pend_addr_reg;
                mem_wdata  = mem_rdata;
                cnt_next   = BOTTOM_ROW;
                state_next = tcc_pkg::ST_BLANK;
            end

            // Blank the bottom row.
            tcc_pkg::ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = blank_cell;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = tcc_pkg::ST_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Hand the result over once the output stage has room.
            tcc_pkg::ST_RESP:
            begin
                resp_valid = 1'b1;
                if (resp_ready)
                begin
                    state_next = tcc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Result payload from the cursor and the registered read data.
    always_comb
    begin
        resp_data.cell_data  = read_ok_reg ? mem_rdata : '0;
        resp_data.cursor_row = tcc_pkg::ROW_OUT_W'(row_reg);
        resp_data.cursor_col = tcc_pkg::COL_OUT_W'(col_reg);
        resp_data.scrolled   = scrolled_reg;
    end

`ifndef SYNTHESIS
    // The cursor never leaves the screen.
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < 32'(COLUMNS)) && (32'(row_reg) < 32'(ROWS)))
        else $error("cursor outside the screen");

    // Every memory write lands inside the store.
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(mem_waddr) < 32'(CELLS)))
        else $error("memory write beyond the last cell");

    // A scrolled result always leaves the cursor on the last row.
    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && scrolled_reg) |-> (row_reg == LAST_ROW))
        else $error("scroll without cursor on the last row");

    // An accepted request moves to the result or the scroll copy next cycle.
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=>
        (state_reg == tcc_pkg::ST_RESP || state_reg == tcc_pkg::ST_COPY))
        else $error("accepted request did not advance");

    // A read result never reports a scroll.
    a_read_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && read_ok_reg) |-> !scrolled_reg)
        else $error("read result flagged as scrolled");
`endif

endmodule
`default_nettype wire

FILE: hdl/text_console_cursor_scroll.sv
`default_nettype none
// A request is accepted while the block is idle and its result is registered
// at the output; a new request is not accepted until the previous result
// has been handed to the output register. A request that scrolls copies the
// store through the memory port, one cell per cycle.
// Reset: cursor to 0, attribute to 07; a clearing pass then writes every cell,
// during which no request is accepted.
// ----------------------------------------------------------------------------
// text_console_cursor_scroll: character console engine
// Keeps a ROWS x COLUMNS screen of attribute/character cells with a cursor,
// handles put, newline, backspace and scroll, and reads back single cells.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
    parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire tcc_pkg::in_t               in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output tcc_pkg::out_t                   out_data,
    input  wire logic                       cfg_wr_en,
    input  wire logic [tcc_pkg::ATTR_W-1:0] cfg_wr_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic                       resp_valid;
    logic                       resp_ready;
    tcc_pkg::out_t              resp_data;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [tcc_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [tcc_pkg::CELL_W-1:0] mem_rdata;

    logic                       out_valid_reg, out_valid_next;
    tcc_pkg::out_t              out_data_reg;

    tcc_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .resp_valid  (resp_valid),
        .resp_ready  (resp_ready),
        .resp_data   (resp_data),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    tcc_screen_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: takes a result when empty or being drained.
    assign resp_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (resp_valid && resp_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp_valid && resp_ready)
        begin
            out_data_reg <= resp_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the text console engine
// Sends put and read requests with random gaps on the request side and random
// stalls on the result side. A local copy of the screen store, cursor and
// attribute register predicts every result, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int COLUMNS    = tcc_pkg::DEF_COLUMNS;
    localparam int ROWS       = tcc_pkg::DEF_ROWS;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int IDX_MAX    = (1 << tcc_pkg::IDX_W) - 1;
    localparam int MAX_WAIT   = 15;
    localparam int IDLE_LIMIT = 20000;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    tcc_pkg::in_t               in_data     = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    tcc_pkg::out_t              out_data;
    logic                       cfg_wr_en   = 1'b0;
    logic [tcc_pkg::ATTR_W-1:0] cfg_wr_data = '0;

    // Local copy of the console state.
    logic [tcc_pkg::CELL_W-1:0] screen_mirror [CELLS];
    int                         mirror_row;
    int                         mirror_col;
    logic [tcc_pkg::ATTR_W-1:0] mirror_attr;
    tcc_pkg::out_t              console_replies [$];

    int errors          = 0;
    int replies_checked = 0;
    int requests_sent   = 0;
    int reads_sent      = 0;
    int wrap_count      = 0;
    int scroll_count    = 0;
    int attr_writes     = 0;
    int idle_cycles     = 0;
    int out_stall       = 0;
    bit in_burst        = 1'b0;
    bit out_burst       = 1'b0;

    text_console_cursor_scroll #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Free-running clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Move the cursor down one row; leaving the last row scrolls the store up.
    function automatic bit advance_row();
        mirror_row++;
        if (mirror_row < ROWS)
            return 1'b0;
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen_mirror[ADDR_W'(i)] = screen_mirror[ADDR_W'(i + COLUMNS)];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_mirror[ADDR_W'(i)] = {mirror_attr, tcc_pkg::BLANK_CHAR};
        mirror_row = ROWS - 1;
        scroll_count++;
        return 1'b1;
    endfunction

    // Apply one accepted request to the local state and return its result.
    function automatic tcc_pkg::out_t apply_console_request(input tcc_pkg::in_t req);
        tcc_pkg::out_t rsp;
        rsp = '0;
        if (req.action == tcc_pkg::ACT_READ)
        begin
            if (32'(req.cell_index) < CELLS)
                rsp.cell_data = screen_mirror[ADDR_W'(req.cell_index)];
        end
        else if (req.char_code == tcc_pkg::NEWLINE_CHAR)
        begin
            mirror_col   = 0;
            rsp.scrolled = advance_row();
        end
        else if (req.char_code == tcc_pkg::BACKSPACE_CHAR)
        begin
            // At column zero a backspace leaves everything alone.
            if (mirror_col > 0)
            begin
                mirror_col--;
                screen_mirror[ADDR_W'(mirror_row * COLUMNS + mirror_col)] =
                    {mirror_attr, tcc_pkg::BLANK_CHAR};
            end
        end
        else
        begin
            screen_mirror[ADDR_W'(mirror_row * COLUMNS + mirror_col)] =
                {mirror_attr, req.char_code};
            mirror_col++;
            if (mirror_col >= COLUMNS)
            begin
                mirror_col   = 0;
                wrap_count++;
                rsp.scrolled = advance_row();
            end
        end
        rsp.cursor_row = mirror_row[tcc_pkg::ROW_OUT_W-1:0];
        rsp.cursor_col = mirror_col[tcc_pkg::COL_OUT_W-1:0];
        return rsp;
    endfunction

    function automatic tcc_pkg::in_t put_request(input logic [tcc_pkg::CHAR_W-1:0] ch);
        tcc_pkg::in_t req;
        req            = '0;
        req.action     = tcc_pkg::ACT_PUT;
        req.char_code  = ch;
        req.cell_index = tcc_pkg::IDX_W'($urandom_range(0, IDX_MAX));
        return req;
    endfunction

    function automatic tcc_pkg::in_t read_request(input int idx);
        tcc_pkg::in_t req;
        req            = '0;
        req.action     = tcc_pkg::ACT_READ;
        req.char_code  = tcc_pkg::CHAR_W'($urandom_range(0, 255));
        req.cell_index = idx[tcc_pkg::IDX_W-1:0];
        return req;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("ERROR: result %0d, %s: got 0x%0h, expected 0x%0h",
                 replies_checked, field, got, want);
    endtask

    // Send one request after a random gap and predict its result on acceptance.
    task automatic send_request(input tcc_pkg::in_t req);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        console_replies.push_back(apply_console_request(req));
        requests_sent++;
        if (req.action == tcc_pkg::ACT_READ)
            reads_sent++;
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_for_replies();
        in_valid <= 1'b0;
        while (console_replies.size() != 0)
            @(posedge clk);
    endtask

    // Write the attribute register while the block is idle.
    task automatic write_attribute(input logic [tcc_pkg::ATTR_W-1:0] value);
        wait_for_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mirror_attr = value;
        attr_writes++;
        @(posedge clk);
    endtask

    task automatic check_reply(input tcc_pkg::out_t got);
        tcc_pkg::out_t want;
        if (console_replies.size() == 0)
        begin
            report_mismatch("result with no request pending", 32'(got), '0);
        end
        else
        begin
            want = console_replies.pop_front();
            if (got.cell_data !== want.cell_data)
                report_mismatch("cell_data", 32'(got.cell_data), 32'(want.cell_data));
            if (got.cursor_row !== want.cursor_row)
                report_mismatch("cursor_row", 32'(got.cursor_row), 32'(want.cursor_row));
            if (got.cursor_col !== want.cursor_col)
                report_mismatch("cursor_col", 32'(got.cursor_col), 32'(want.cursor_col));
            if (got.scrolled !== want.scrolled)
                report_mismatch("scrolled", 32'(got.scrolled), 32'(want.scrolled));
        end
        replies_checked++;
    endtask

    // Result side: check each accepted result, then stall for a random count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_ready)
            begin
                check_reply(out_data);
                out_stall = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
                if (out_stall > 0)
                    out_ready <= 1'b0;
            end
            else if (!out_ready)
            begin
                if (out_stall > 0)
                    out_stall--;
                if (out_stall == 0)
                    out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no handshake completes for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("text_console_cursor_scroll test failed");
            $finish;
        end
    end

    // Reads of the blank screen, three of its corners and indexes past the end.
    task automatic test_reset_screen();
        send_request(read_request(0));
        send_request(read_request(1));
        send_request(read_request(COLUMNS - 1));
        send_request(read_request(CELLS - 1));
        send_request(read_request(CELLS));
        send_request(read_request(IDX_MAX));
    endtask

    // Character extremes, newline and both backspace cases.
    task automatic test_put_controls();
        send_request(put_request(8'h41));
        send_request(put_request(8'h00));
        send_request(put_request(8'hFF));
        send_request(put_request(8'h80));
        send_request(put_request(tcc_pkg::BACKSPACE_CHAR));
        send_request(read_request(2));
        send_request(read_request(3));
        send_request(put_request(tcc_pkg::NEWLINE_CHAR));
        send_request(put_request(tcc_pkg::BACKSPACE_CHAR));
        send_request(put_request(8'h7F));
        send_request(read_request(COLUMNS));
        send_request(read_request(0));
        send_request(read_request(1));
    endtask

    // Both attribute extremes on written and blanked cells.
    task automatic test_attribute_extremes();
        write_attribute(8'hFF);
        send_request(put_request(8'h5A));
        send_request(put_request(8'h7E));
        send_request(put_request(tcc_pkg::BACKSPACE_CHAR));
        send_request(read_request(mirror_row * COLUMNS + mirror_col - 1));
        send_request(read_request(mirror_row * COLUMNS + mirror_col));
        write_attribute(8'h00);
        send_request(put_request(8'h55));
        send_request(read_request(mirror_row * COLUMNS + mirror_col - 1));
    endtask

    // Lines of text ended by a newline, some long enough to wrap, with reads
    // near the cursor. Once the cursor sits on the last row, lines scroll.
    task automatic test_text_lines(input int budget);
        int sent;
        int len;
        int roll;
        sent = 0;
        while (sent < budget)
        begin
            roll = $urandom_range(0, 9);
            len  = (roll == 0) ? $urandom_range(COLUMNS - 5, COLUMNS + 20)
                               : $urandom_range(0, 24);
            for (int k = 0; k < len && sent < budget; k++)
            begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    send_request(put_request(tcc_pkg::BACKSPACE_CHAR));
                else if (roll == 1)
                    send_request(read_request(mirror_row * COLUMNS +
                                              $urandom_range(0, COLUMNS - 1)));
                else if (roll == 2)
                    send_request(put_request(tcc_pkg::CHAR_W'($urandom_range(0, 255))));
                else
                    send_request(put_request(
                        tcc_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E))));
                sent++;
            end
            send_request(put_request(tcc_pkg::NEWLINE_CHAR));
            send_request(read_request($urandom_range(0, CELLS - 1)));
            sent += 2;
        end
    endtask

    // Unstructured requests over the whole range of every field.
    task automatic test_noise(input int budget);
        tcc_pkg::in_t req;
        for (int k = 0; k < budget; k++)
        begin
            req            = '0;
            req.action     = 1'($urandom_range(0, 1));
            req.char_code  = tcc_pkg::CHAR_W'($urandom_range(0, 255));
            req.cell_index = tcc_pkg::IDX_W'($urandom_range(0, IDX_MAX));
            send_request(req);
        end
    endtask

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            screen_mirror[ADDR_W'(i)] = tcc_pkg::RESET_CELL;
        mirror_row  = 0;
        mirror_col  = 0;
        mirror_attr = tcc_pkg::ATTR_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_screen();
        test_put_controls();
        test_attribute_extremes();

        write_attribute(tcc_pkg::ATTR_W'($urandom_range(0, 255)));
        in_burst  = 1'b0;
        out_burst = 1'b0;
        test_text_lines(300);

        write_attribute(tcc_pkg::ATTR_W'($urandom_range(0, 255)));
        in_burst  = 1'b1;
        out_burst = 1'b1;
        test_text_lines(150);

        in_burst  = 1'b0;
        out_burst = 1'b1;
        test_noise(150);

        write_attribute(tcc_pkg::ATTR_W'($urandom_range(0, 255)));
        in_burst  = 1'b1;
        out_burst = 1'b0;
        test_text_lines(200);

        in_burst  = 1'b0;
        out_burst = 1'b0;
        test_noise(150);

        // Drain, then give a stray result time to show up.
        wait_for_replies();
        repeat (64) @(posedge clk);

        $display("Coverage: %0d requests (%0d reads), %0d line wraps, %0d scrolls.",
                 requests_sent, reads_sent, wrap_count, scroll_count);
        $display("Attribute written %0d times; %0d results checked, %0d mismatches.",
                 attr_writes, replies_checked, errors);
        if (errors == 0)
            $display("text_console_cursor_scroll test passed");
        else
            $display("text_console_cursor_scroll test failed");
        $finish;
    end

endmodule
